>>> rtl/tftp_packet_validator_top_assert.svh
// Assertion macros for the TFTP packet validator.
// Every check is sampled on the rising edge of clk and is switched off during reset.
`ifndef TFTP_PACKET_VALIDATOR_TOP_ASSERT_SVH
`define TFTP_PACKET_VALIDATOR_TOP_ASSERT_SVH

// Check a property that holds on a single clock edge.
`define TPV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a trigger on one edge implies a consequence on the next edge.
`define TPV_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

>>> rtl/tpv_pkg.sv
// ----------------------------------------------------------------------------
// tpv_pkg
// Shared types and codes of the TFTP packet validator.
// ----------------------------------------------------------------------------
`default_nettype none

package tpv_pkg;

  // Parse phases
  typedef enum logic [3:0] {
    PH_OP_HI  = 4'd0,
    PH_OP_LO  = 4'd1,
    PH_NUM_HI = 4'd2,
    PH_NUM_LO = 4'd3,
    PH_FNAME  = 4'd4,
    PH_MODE   = 4'd5,
    PH_TAIL   = 4'd6,
    PH_DATA   = 4'd7,
    PH_ACKEND = 4'd8,
    PH_EMSG   = 4'd9
  } phase_t;

  // Packet kinds: the opcode minus one
  localparam logic [2:0] KIND_RRQ   = 3'd0;
  localparam logic [2:0] KIND_WRQ   = 3'd1;
  localparam logic [2:0] KIND_DATA  = 3'd2;
  localparam logic [2:0] KIND_ACK   = 3'd3;
  localparam logic [2:0] KIND_ERROR = 3'd4;

  // Transfer modes
  localparam logic [1:0] MODE_NETASCII = 2'd0;
  localparam logic [1:0] MODE_OCTET    = 2'd1;
  localparam logic [1:0] MODE_MAIL     = 2'd2;

  typedef struct packed {
    logic [7:0] packet_byte;
    logic       last_byte;
  } byte_t;

  typedef struct packed {
    logic        packet_valid;
    logic [2:0]  packet_kind;
    logic [15:0] number_field;
    logic [9:0]  data_length;
    logic [1:0]  transfer_mode;
  } result_t;

  // Parser state carried from byte to byte
  typedef struct packed {
    phase_t      parse_phase;
    logic [2:0]  opcode_seen;
    logic [15:0] number_value;
    logic [9:0]  byte_count;
    logic [1:0]  mode_candidate;
    logic [3:0]  token_position;
    logic        char_seen;
    logic        match_failed;
  } parse_state_t;

  localparam parse_state_t PARSE_RESET = '{
    parse_phase:    PH_OP_HI,
    opcode_seen:    3'd0,
    number_value:   16'd0,
    byte_count:     10'd0,
    mode_candidate: 2'd0,
    token_position: 4'd0,
    char_seen:      1'b0,
    match_failed:   1'b0
  };

endpackage

`default_nettype wire

>>> rtl/tpv_step.sv
// ----------------------------------------------------------------------------
// tpv_step
// Next parser state for one packet byte, given the current state.
// ----------------------------------------------------------------------------
`default_nettype none

module tpv_step
  import tpv_pkg::*;
#(
  parameter int MAX_DATA_BYTES = 512
) (
  input  wire parse_state_t cur,
  input  wire logic [7:0]   packet_byte,
  output parse_state_t      nxt
);

  localparam logic [9:0] MAX_COUNT = 10'(MAX_DATA_BYTES);

  localparam logic [7:0] TOK_NETASCII [8] = '{8'h6E, 8'h65, 8'h74, 8'h61,
                                              8'h73, 8'h63, 8'h69, 8'h69};
  localparam logic [7:0] TOK_OCTET    [5] = '{8'h6F, 8'h63, 8'h74, 8'h65, 8'h74};
  localparam logic [7:0] TOK_MAIL     [4] = '{8'h6D, 8'h61, 8'h69, 8'h6C};

  function automatic logic name_char(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h30 && c <= 8'h39) || c == 8'h2E || c == 8'h5F ||
           c == 8'h2F || c == 8'h2D || c == 8'h20;
  endfunction

  function automatic logic msg_char(input logic [7:0] c);
    return (c >= 8'h01 && c <= 8'h04) || (c >= 8'h09 && c <= 8'h0D) ||
           (c >= 8'h20 && c <= 8'h7E);
  endfunction

  function automatic logic [3:0] tok_len(input logic [1:0] m);
    logic [3:0] len;
    if (m == MODE_NETASCII) len = 4'd8;
    else if (m == MODE_OCTET) len = 4'd5;
    else len = 4'd4;
    return len;
  endfunction

  function automatic logic [7:0] tok_char(input logic [1:0] m, input logic [3:0] pos);
    logic [7:0] ch;
    if (m == MODE_NETASCII) ch = TOK_NETASCII[pos[2:0]];
    else if (m == MODE_OCTET) ch = (pos < 4'd5) ? TOK_OCTET[pos[2:0]] : 8'h00;
    else ch = (pos < 4'd4) ? TOK_MAIL[pos[1:0]] : 8'h00;
    return ch;
  endfunction

  logic [15:0] number_full;

  assign number_full = {cur.number_value[15:8], packet_byte};

  always_comb begin
    nxt = cur;
    if (!cur.match_failed) begin
      unique case (cur.parse_phase)
        PH_OP_HI: begin
          if (packet_byte != 8'd0) nxt.match_failed = 1'b1;
          else nxt.parse_phase = PH_OP_LO;
        end
        PH_OP_LO: begin
          if (packet_byte < 8'd1 || packet_byte > 8'd5) begin
            nxt.match_failed = 1'b1;
          end else begin
            nxt.opcode_seen = 3'(packet_byte - 8'd1);
            nxt.parse_phase = (packet_byte <= 8'd2) ? PH_FNAME : PH_NUM_HI;
          end
        end
        PH_NUM_HI: begin
          nxt.number_value = {packet_byte, 8'h00};
          nxt.parse_phase  = PH_NUM_LO;
        end
        PH_NUM_LO: begin
          nxt.number_value = number_full;
          if (cur.opcode_seen == KIND_DATA) begin
            if (number_full == 16'd0) nxt.match_failed = 1'b1;
            else nxt.parse_phase = PH_DATA;
          end else if (cur.opcode_seen == KIND_ACK) begin
            nxt.parse_phase = PH_ACKEND;
          end else begin
            if (number_full > 16'd7) nxt.match_failed = 1'b1;
            else nxt.parse_phase = PH_EMSG;
          end
        end
        PH_FNAME: begin
          if (packet_byte == 8'd0) begin
            if (cur.char_seen) begin
              nxt.parse_phase    = PH_MODE;
              nxt.token_position = 4'd0;
            end else begin
              nxt.match_failed = 1'b1;
            end
          end else if (name_char(packet_byte)) begin
            nxt.char_seen = 1'b1;
          end else begin
            nxt.match_failed = 1'b1;
          end
        end
        PH_MODE: begin
          if (cur.token_position == 4'd0) begin
            // pick the token from its first letter
            if (packet_byte == 8'h6E) begin
              nxt.mode_candidate = MODE_NETASCII;
              nxt.token_position = 4'd1;
            end else if (packet_byte == 8'h6F) begin
              nxt.mode_candidate = MODE_OCTET;
              nxt.token_position = 4'd1;
            end else if (packet_byte == 8'h6D) begin
              nxt.mode_candidate = MODE_MAIL;
              nxt.token_position = 4'd1;
            end else begin
              nxt.match_failed = 1'b1;
            end
          end else if (cur.token_position >= tok_len(cur.mode_candidate)) begin
            if (packet_byte == 8'd0) nxt.parse_phase = PH_TAIL;
            else nxt.match_failed = 1'b1;
          end else if (packet_byte == tok_char(cur.mode_candidate, cur.token_position)) begin
            nxt.token_position = cur.token_position + 4'd1;
          end else begin
            nxt.match_failed = 1'b1;
          end
        end
        PH_DATA: begin
          if (cur.byte_count >= MAX_COUNT) nxt.match_failed = 1'b1;
          else nxt.byte_count = cur.byte_count + 10'd1;
        end
        PH_ACKEND: nxt.match_failed = 1'b1;
        PH_EMSG: begin
          if (packet_byte == 8'd0) begin
            if (cur.char_seen) nxt.parse_phase = PH_TAIL;
            else nxt.match_failed = 1'b1;
          end else if (msg_char(packet_byte)) begin
            nxt.char_seen = 1'b1;
          end else begin
            nxt.match_failed = 1'b1;
          end
        end
        // trailing bytes after a closing zero, and unused phase codes: hold
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/tftp_packet_validator_top.sv
// ----------------------------------------------------------------------------
// tftp_packet_validator_top
// Byte-serial TFTP packet grammar checker with a registered result port.
// ----------------------------------------------------------------------------
// The block takes one packet byte per request, one request per clock cycle
// while byte_stall is low, and produces one result request in the cycle after
// the request that carries last_byte. Each byte updates a small parser state
// through one level of next-state logic, so the rate is set only by that state
// register: one byte per cycle while no result is stalled, with no gap between
// packets. The result sits in a single output register; while it is held by
// result_stall, byte_stall is raised and no byte is taken. The parser returns
// to its reset state after every final byte. Requests and error packets stay
// valid when extra bytes follow their closing zero; a data packet counts at
// most MAX_DATA_BYTES data bytes and fails on more.
`default_nettype none

module tftp_packet_validator_top
  import tpv_pkg::*;
#(
  parameter int MAX_DATA_BYTES = 512
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    byte_valid,
  output logic         byte_stall,
  input  wire byte_t   byte_data,
  output logic         result_valid,
  input  wire logic    result_stall,
  output result_t      result_data
);

  `include "tftp_packet_validator_top_assert.svh"

  parse_state_t state;
  parse_state_t state_next;
  result_t      result_next;
  logic         byte_accept;
  logic         last_accept;
  logic         ok;
  logic         request;

  // Hold input while the finished result waits to be taken.
  assign byte_stall  = result_valid && result_stall;
  assign byte_accept = byte_valid && !byte_stall;
  assign last_accept = byte_accept && byte_data.last_byte;

  tpv_step #(
    .MAX_DATA_BYTES(MAX_DATA_BYTES)
  ) u_step (
    .cur        (state),
    .packet_byte(byte_data.packet_byte),
    .nxt        (state_next)
  );

  // Build the result from the state after the final byte.
  assign ok = !state_next.match_failed &&
              (state_next.parse_phase == PH_TAIL || state_next.parse_phase == PH_DATA ||
               state_next.parse_phase == PH_ACKEND);
  assign request = state_next.opcode_seen <= KIND_WRQ;

  always_comb begin
    result_next.packet_valid  = ok;
    result_next.packet_kind   = state_next.opcode_seen;
    result_next.number_field  = request ? 16'd0 : state_next.number_value;
    result_next.data_length   = (state_next.opcode_seen == KIND_DATA) ?
                                state_next.byte_count : 10'd0;
    result_next.transfer_mode = (ok && request) ? state_next.mode_candidate : MODE_NETASCII;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= PARSE_RESET;
      result_valid <= 1'b0;
    end else begin
      // Advance the parser; restart it after the final byte.
      if (byte_accept) begin
        state <= byte_data.last_byte ? PARSE_RESET : state_next;
      end
      if (last_accept) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Payload register: load on each final byte.
  always_ff @(posedge clk) begin
    if (last_accept) begin
      result_data <= result_next;
    end
  end

  `TPV_ASSERT_NEXT(a_last_gives_result, last_accept, result_valid,
                   "final byte did not produce a result")
  `TPV_ASSERT_NEXT(a_parser_restarts, last_accept,
                   state.parse_phase == PH_OP_HI && !state.match_failed && !state.char_seen,
                   "parser not restarted after final byte")
  `TPV_ASSERT(a_mode_only_valid_request,
              !result_valid || result_data.transfer_mode == MODE_NETASCII ||
              (result_data.packet_valid && result_data.packet_kind <= KIND_WRQ),
              "transfer mode reported for a packet that is not a valid request")
  `TPV_ASSERT(a_length_only_data,
              !result_valid || result_data.data_length == 10'd0 ||
              (result_data.packet_kind == KIND_DATA &&
               result_data.data_length <= 10'(MAX_DATA_BYTES)),
              "data length out of range or on a non-data packet")

endmodule

`default_nettype wire

>>> dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the byte-serial TFTP packet validator.
// ----------------------------------------------------------------------------
// Packets are sent one byte per request on the byte channel. The last byte is
// flagged. A parser model in this file follows every accepted byte and queues
// the result due on each final byte. A monitor pops that queue for every
// accepted result request and compares it field by field. Directed packets
// come first: one task for requests, one per other packet kind, one for bad opcodes.
// Random packets follow: most are well formed with random content, and the
// rest are broken or plain noise. Random sender gaps and receiver stalls change by phase.

module tb_top;
  import tpv_pkg::*;

  localparam int DATA_LIMIT   = 512;
  localparam int RANDOM_BYTES = 120;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 200000;

  // Opcodes as they appear in the low byte of the header
  localparam logic [7:0] OP_RRQ   = 8'd1;
  localparam logic [7:0] OP_WRQ   = 8'd2;
  localparam logic [7:0] OP_DATA  = 8'd3;
  localparam logic [7:0] OP_ACK   = 8'd4;
  localparam logic [7:0] OP_ERROR = 8'd5;

  typedef logic [7:0] octet_q_t[$];

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    byte_valid = 1'b0;
  logic    byte_stall;
  byte_t   byte_data = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result_data;

  // Idle mix in percent, changed between phases of the run
  int send_idle_pct  = 28;
  int recv_stall_pct = 52;

  // Parser model state and the results it still owes
  parse_state_t parser = PARSE_RESET;
  result_t      expected_results[$];
  result_t      want_result;

  int fail_count      = 0;
  int packets_sent    = 0;
  int bytes_sent      = 0;
  int results_checked = 0;
  int valid_results   = 0;
  int cycle_count     = 0;

  tftp_packet_validator_top #(
    .MAX_DATA_BYTES(DATA_LIMIT)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .byte_data    (byte_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_top: timeout after %0d cycles, %0d results still due",
               cycle_count, expected_results.size());
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Character classes and mode tokens of the packet grammar
  // ---------------------------------------------------------------------------
  function automatic bit name_char(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") ||
           (b >= "0" && b <= "9") || b == "." || b == "_" ||
           b == "/" || b == "-" || b == " ";
  endfunction

  function automatic bit msg_char(input logic [7:0] b);
    return (b >= 8'h01 && b <= 8'h04) || (b >= 8'h09 && b <= 8'h0D) ||
           (b >= 8'h20 && b <= 8'h7E);
  endfunction

  function automatic string mode_token(input logic [1:0] mode);
    case (mode)
      MODE_NETASCII: return "netascii";
      MODE_OCTET:    return "octet";
      default:       return "mail";
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Parser model: advance on one byte, close the packet on the final byte
  // ---------------------------------------------------------------------------
  function automatic void parse_byte(input logic [7:0] b);
    string token;
    // Once a packet has failed, drop every byte up to the final one.
    if (parser.match_failed) return;
    case (parser.parse_phase)
      PH_OP_HI: begin
        if (b != 8'h00) parser.match_failed = 1'b1;
        else parser.parse_phase = PH_OP_LO;
      end
      PH_OP_LO: begin
        if (b < OP_RRQ || b > OP_ERROR) begin
          parser.match_failed = 1'b1;
        end else begin
          parser.opcode_seen = 3'(b - 8'd1);
          parser.parse_phase = (b <= OP_WRQ) ? PH_FNAME : PH_NUM_HI;
        end
      end
      PH_NUM_HI: begin
        parser.number_value = {b, 8'h00};
        parser.parse_phase  = PH_NUM_LO;
      end
      PH_NUM_LO: begin
        parser.number_value = parser.number_value | 16'(b);
        if (parser.opcode_seen == KIND_DATA) begin
          // Block zero is not a legal data block.
          if (parser.number_value == 16'd0) parser.match_failed = 1'b1;
          else parser.parse_phase = PH_DATA;
        end else if (parser.opcode_seen == KIND_ACK) begin
          parser.parse_phase = PH_ACKEND;
        end else begin
          if (parser.number_value > 16'd7) parser.match_failed = 1'b1;
          else parser.parse_phase = PH_EMSG;
        end
      end
      PH_FNAME: begin
        if (b == 8'h00) begin
          if (parser.char_seen) begin
            parser.parse_phase    = PH_MODE;
            parser.token_position = 4'd0;
          end else begin
            parser.match_failed = 1'b1;
          end
        end else if (name_char(b)) begin
          parser.char_seen = 1'b1;
        end else begin
          parser.match_failed = 1'b1;
        end
      end
      PH_MODE: begin
        if (parser.token_position == 4'd0) begin
          // The first letter picks the token to match.
          parser.token_position = 4'd1;
          if (b == "n") parser.mode_candidate = MODE_NETASCII;
          else if (b == "o") parser.mode_candidate = MODE_OCTET;
          else if (b == "m") parser.mode_candidate = MODE_MAIL;
          else parser.match_failed = 1'b1;
        end else begin
          token = mode_token(parser.mode_candidate);
          if (parser.token_position >= token.len()) begin
            if (b == 8'h00) parser.parse_phase = PH_TAIL;
            else parser.match_failed = 1'b1;
          end else if (b == token[parser.token_position]) begin
            parser.token_position = parser.token_position + 4'd1;
          end else begin
            parser.match_failed = 1'b1;
          end
        end
      end
      PH_DATA: begin
        // Hold the count at the limit and fail on one byte more.
        if (parser.byte_count >= DATA_LIMIT) parser.match_failed = 1'b1;
        else parser.byte_count = parser.byte_count + 10'd1;
      end
      PH_ACKEND: parser.match_failed = 1'b1;
      PH_EMSG: begin
        if (b == 8'h00) begin
          if (parser.char_seen) parser.parse_phase = PH_TAIL;
          else parser.match_failed = 1'b1;
        end else if (msg_char(b)) begin
          parser.char_seen = 1'b1;
        end else begin
          parser.match_failed = 1'b1;
        end
      end
      default: ; // trailing bytes after a closing zero: ignore
    endcase
  endfunction

  function automatic result_t close_packet();
    result_t r;
    logic    ok;
    logic    request;
    ok = !parser.match_failed &&
         (parser.parse_phase == PH_TAIL || parser.parse_phase == PH_DATA ||
          parser.parse_phase == PH_ACKEND);
    // An opcode that was never read leaves kind zero, which reads as a request.
    request = (parser.opcode_seen <= KIND_WRQ);
    r.packet_valid  = ok;
    r.packet_kind   = parser.opcode_seen;
    r.number_field  = request ? 16'd0 : parser.number_value;
    r.data_length   = (parser.opcode_seen == KIND_DATA) ? parser.byte_count : 10'd0;
    r.transfer_mode = (ok && request) ? parser.mode_candidate : 2'd0;
    parser = PARSE_RESET;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Byte channel: send one byte, and whole packets built from bytes
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic last);
    // Idle the sender for a random number of cycles first.
    while ($urandom_range(0, 99) < send_idle_pct) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_data  <= '{packet_byte: b, last_byte: last};
    // Hold the request until an edge sees it with stall low.
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    bytes_sent++;
    parse_byte(b);
    if (last) expected_results.push_back(close_packet());
  endtask

  task automatic send_packet(input octet_q_t pkt);
    for (int i = 0; i < pkt.size(); i++) send_byte(pkt[i], i == pkt.size() - 1);
    packets_sent++;
  endtask

  function automatic void push_word(ref octet_q_t pkt, input logic [15:0] w);
    pkt.push_back(w[15:8]);
    pkt.push_back(w[7:0]);
  endfunction

  function automatic void push_text(ref octet_q_t pkt, input string s);
    for (int i = 0; i < s.len(); i++) pkt.push_back(s[i]);
  endfunction

  function automatic void truncate_packet(ref octet_q_t pkt, input int keep);
    while (pkt.size() > keep) void'(pkt.pop_back());
  endfunction

  function automatic octet_q_t request_packet(input logic [7:0] op, input string name,
                                              input string mode);
    octet_q_t pkt;
    push_word(pkt, 16'(op));
    push_text(pkt, name);
    pkt.push_back(8'h00);
    push_text(pkt, mode);
    pkt.push_back(8'h00);
    return pkt;
  endfunction

  function automatic octet_q_t data_packet(input logic [15:0] block, input int len);
    octet_q_t pkt;
    push_word(pkt, 16'(OP_DATA));
    push_word(pkt, block);
    repeat (len) pkt.push_back(8'($urandom_range(0, 255)));
    return pkt;
  endfunction

  function automatic octet_q_t ack_packet(input logic [15:0] block);
    octet_q_t pkt;
    push_word(pkt, 16'(OP_ACK));
    push_word(pkt, block);
    return pkt;
  endfunction

  function automatic octet_q_t error_packet(input logic [15:0] code, input string msg);
    octet_q_t pkt;
    push_word(pkt, 16'(OP_ERROR));
    push_word(pkt, code);
    push_text(pkt, msg);
    pkt.push_back(8'h00);
    return pkt;
  endfunction

  // Build a random string from the filename or the error message character class.
  function automatic string random_text(input int len, input bit filename);
    string      s;
    logic [7:0] c;
    s = "";
    repeat (len) s = {s, "a"};
    for (int i = 0; i < len; i++) begin
      do c = 8'($urandom_range(1, 255));
      while (!(filename ? name_char(c) : msg_char(c)));
      s.putc(i, c);
    end
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Result channel: random stall, then check every accepted result request
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  function automatic void check_field(input string field, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", field, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (expected_results.size() == 0) begin
        $error("result with no packet closed: %p", result_data);
        fail_count++;
      end else begin
        want_result = expected_results.pop_front();
        check_field("packet_valid", want_result.packet_valid, result_data.packet_valid);
        check_field("packet_kind", want_result.packet_kind, result_data.packet_kind);
        check_field("number_field", want_result.number_field, result_data.number_field);
        check_field("data_length", want_result.data_length, result_data.data_length);
        check_field("transfer_mode", want_result.transfer_mode,
                    result_data.transfer_mode);
        results_checked++;
        if (result_data.packet_valid) valid_results++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_requests();
    octet_q_t pkt;
    // Each mode token, the shortest name, every filename character class.
    send_packet(request_packet(OP_RRQ, "a", "netascii"));
    pkt = request_packet(OP_WRQ, "dir/File_1.-x y", "octet");
    pkt.push_back(8'hFF);  // trailing bytes: ignore, packet stays valid
    pkt.push_back(8'h00);
    send_packet(pkt);
    send_packet(request_packet(OP_RRQ, "Z09", "mail"));
    // Empty filename, illegal filename character, wrong and misspelled tokens.
    send_packet(request_packet(OP_WRQ, "", "octet"));
    send_packet(request_packet(OP_RRQ, "bad!name", "mail"));
    send_packet(request_packet(OP_RRQ, "f", "octed"));
    send_packet(request_packet(OP_WRQ, "f", "NETASCII"));
    send_packet(request_packet(OP_WRQ, "f", "mailx"));
    // Short: the token is complete but its closing zero never comes.
    pkt = request_packet(OP_RRQ, "file", "netascii");
    truncate_packet(pkt, pkt.size() - 1);
    send_packet(pkt);
  endtask

  task automatic test_data_packets();
    octet_q_t pkt;
    send_packet(data_packet(16'd1, 0));                    // empty data
    // One byte over: the count holds at the limit and the packet fails.
    send_packet(data_packet(16'hFFFF, DATA_LIMIT + 1));
    send_packet(data_packet(16'd0, 2));                    // block zero
    pkt = data_packet(16'd5, 0);
    truncate_packet(pkt, 3);                               // short header
    send_packet(pkt);
  endtask

  task automatic test_ack_packets();
    octet_q_t pkt;
    send_packet(ack_packet(16'd0));
    pkt = ack_packet(16'hFFFF);
    send_packet(pkt);
    pkt.push_back(8'h00);                                  // extra ack byte
    send_packet(pkt);
    truncate_packet(pkt, 3);
    send_packet(pkt);
  endtask

  task automatic test_error_packets();
    octet_q_t pkt;
    send_packet(error_packet(16'd0, "x"));
    // Edges of every message character range, then trailing bytes.
    pkt = error_packet(16'd7, "\001\004\011\015 ~");
    pkt.push_back(8'h80);
    send_packet(pkt);
    send_packet(error_packet(16'd8, "oops"));
    send_packet(error_packet(16'h0100, "oops"));
    send_packet(error_packet(16'd1, ""));                  // empty message
    send_packet(error_packet(16'd2, "\177"));              // just above the range
    send_packet(error_packet(16'd3, "\005"));              // in the gap below tab
    pkt = error_packet(16'd4, "msg");
    truncate_packet(pkt, pkt.size() - 1);                  // no closing zero
    send_packet(pkt);
  endtask

  task automatic test_bad_opcodes();
    octet_q_t pkt;
    pkt = {8'h01, 8'h01, 8'h00};                           // nonzero high byte
    send_packet(pkt);
    pkt = {8'h00, 8'h00};
    send_packet(pkt);
    pkt = {8'h00, 8'h06, 8'h41, 8'h00};
    send_packet(pkt);
    pkt = {8'hFF};
    send_packet(pkt);
    pkt = {8'h00};                                         // final byte too soon
    send_packet(pkt);
  endtask

  task automatic test_random_packets(input int byte_budget);
    octet_q_t pkt;
    int       first_byte;
    first_byte = bytes_sent;
    while (bytes_sent - first_byte < byte_budget) begin
      pkt = {};
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4: begin
          pkt = request_packet($urandom_range(0, 1) ? OP_WRQ : OP_RRQ,
                               random_text($urandom_range(1, 8), 1'b1),
                               mode_token(2'($urandom_range(0, 2))));
          if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) pkt.push_back(8'($urandom_range(0, 255)));
          end
        end
        5, 6, 7, 8, 9: begin
          pkt = data_packet($urandom_range(0, 7) == 0 ? 16'd0 :
                            16'($urandom_range(1, 65535)), $urandom_range(0, 16));
        end
        10, 11, 12: pkt = ack_packet(16'($urandom_range(0, 65535)));
        13, 14, 15, 16: begin
          pkt = error_packet($urandom_range(0, 3) == 0 ? 16'($urandom_range(0, 65535)) :
                             16'($urandom_range(0, 7)),
                             random_text($urandom_range(1, 10), 1'b0));
          if ($urandom_range(0, 3) == 0) pkt.push_back(8'($urandom_range(0, 255)));
        end
        default: begin
          repeat ($urandom_range(1, 12)) pkt.push_back(8'($urandom_range(0, 255)));
        end
      endcase
      // Break one packet in four: cut it short, corrupt a byte, or extend it.
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 2))
          0: if (pkt.size() > 1) truncate_packet(pkt, $urandom_range(1, pkt.size() - 1));
          1: pkt[$urandom_range(0, pkt.size() - 1)] = 8'($urandom_range(0, 255));
          default: repeat ($urandom_range(1, 3)) pkt.push_back(8'($urandom_range(0, 255)));
        endcase
      end
      send_packet(pkt);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed packets with a slow receiver.
    test_requests();
    test_data_packets();
    test_ack_packets();
    test_error_packets();
    test_bad_opcodes();

    // Random packets: slow receiver, then slow sender, then full rate.
    test_random_packets(RANDOM_BYTES / 3);
    send_idle_pct  = 52;
    recv_stall_pct = 28;
    test_random_packets(RANDOM_BYTES / 3);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_packets(RANDOM_BYTES / 3);
    byte_valid <= 1'b0;

    // Drain outstanding results, then give any stray result time to show.
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb_top: %0d packets in %0d bytes, %0d results checked, %0d valid",
             packets_sent, bytes_sent, results_checked, valid_results);
    $display("tb_top: all five packet kinds, bad opcodes and noise, three idle mixes");
    if (fail_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
